// ----- rtl/mces_pkg.sv -----
// ----------------------------------------------------------------------------
// mces_pkg: shared types and constants of the Morse element sequencer
// Holds the register index codes, reset durations and the Morse code table.
// ----------------------------------------------------------------------------
package mces_pkg;

  localparam int CHAR_WIDTH    = 8;
  localparam int DUR_WIDTH     = 16;
  localparam int CFG_IDX_WIDTH = 3;
  localparam int NUM_CFG_REGS  = 5;
  localparam int LEN_WIDTH     = 3;
  localparam int MAX_ELEMS     = 5;

  // Reset durations in milliseconds
  localparam int DOT_ON_RESET      = 150;
  localparam int DASH_ON_RESET     = 350;
  localparam int ELEM_GAP_RESET    = 150;
  localparam int SEP_ON_RESET      = 50;
  localparam int SEP_OFF_RESET     = 50;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    CFG_DOT_ON   = 3'd0,
    CFG_DASH_ON  = 3'd1,
    CFG_ELEM_GAP = 3'd2,
    CFG_SEP_ON   = 3'd3,
    CFG_SEP_OFF  = 3'd4
  } cfg_idx_e;

  // Element count and element bits; first element in bit 0, 1 means dash
  typedef struct packed {
    logic [LEN_WIDTH-1:0] len;
    logic [MAX_ELEMS-1:0] bits;
  } morse_code_t;

  localparam morse_code_t LETTER_CODE [26] = '{
    '{3'd2, 5'h02}, '{3'd4, 5'h01}, '{3'd4, 5'h05}, '{3'd3, 5'h01}, // A B C D
    '{3'd1, 5'h00}, '{3'd4, 5'h04}, '{3'd3, 5'h03}, '{3'd4, 5'h00}, // E F G H
    '{3'd2, 5'h00}, '{3'd4, 5'h0E}, '{3'd3, 5'h05}, '{3'd4, 5'h02}, // I J K L
    '{3'd2, 5'h03}, '{3'd2, 5'h01}, '{3'd3, 5'h07}, '{3'd4, 5'h06}, // M N O P
    '{3'd4, 5'h0B}, '{3'd3, 5'h02}, '{3'd3, 5'h00}, '{3'd1, 5'h01}, // Q R S T
    '{3'd3, 5'h04}, '{3'd4, 5'h08}, '{3'd3, 5'h06}, '{3'd4, 5'h09}, // U V W X
    '{3'd4, 5'h0D}, '{3'd4, 5'h03}                                  // Y Z
  };

  localparam morse_code_t DIGIT_CODE [10] = '{
    '{3'd5, 5'h1F}, '{3'd5, 5'h1E}, '{3'd5, 5'h1C}, '{3'd5, 5'h18},
    '{3'd5, 5'h10}, '{3'd5, 5'h00}, '{3'd5, 5'h01}, '{3'd5, 5'h03},
    '{3'd5, 5'h07}, '{3'd5, 5'h0F}
  };

  // Fold lower case, then look up letters and digits; anything else is empty
  function automatic morse_code_t morse_lookup(logic [CHAR_WIDTH-1:0] code);
    logic [CHAR_WIDTH-1:0] ch;
    logic [CHAR_WIDTH-1:0] ofs;
    morse_code_t           res;
    ch  = code;
    res = '0;
    if (ch >= 8'h61 && ch <= 8'h7A) begin
      ch = ch - 8'h20;
    end
    if (ch >= 8'h41 && ch <= 8'h5A) begin
      ofs = ch - 8'h41;
      res = LETTER_CODE[ofs[4:0]];
    end else if (ch >= 8'h30 && ch <= 8'h39) begin
      ofs = ch - 8'h30;
      res = DIGIT_CODE[ofs[3:0]];
    end
    return res;
  endfunction

endpackage

// ----- rtl/morse_code_element_sequencer.sv -----
// ----------------------------------------------------------------------------
// morse_code_element_sequencer: Morse character to lamp segment sequencer
// Looks up each character and shifts its elements out one segment a cycle while not stalled.
// ----------------------------------------------------------------------------
// Flow: an accepted character is registered into the code shift register, then
//   its segments enter the output register one per cycle while not stalled.
//   No new character is taken until its last segment is loaded; one
//   element bit leaves the code shift register every two segments.
// Reset: sequencer idle, output empty, durations at their reset values.
module morse_code_element_sequencer import mces_pkg::*; #(
  parameter int TIME_WIDTH = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [CFG_IDX_WIDTH-1:0]  cfg_addr_i,
  input  logic [TIME_WIDTH-1:0]     cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [CHAR_WIDTH-1:0]     char_code_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic                      main_lamp_o,
  output logic                      sep_lamp_o,
  output logic [DUR_WIDTH-1:0]      duration_o,
  output logic                      last_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ELEM_ON,
    ST_ELEM_GAP,
    ST_SEP_ON,
    ST_SEP_OFF
  } state_e;

  logic [NUM_CFG_REGS-1:0][TIME_WIDTH-1:0] cfg;
  morse_code_t                             lookup;
  state_e                                  state_q;
  logic [MAX_ELEMS-1:0]                    code_q;
  logic [LEN_WIDTH-1:0]                    cnt_q;
  logic                                    out_valid_q;
  logic                                    main_q;
  logic                                    sep_q;
  logic [DUR_WIDTH-1:0]                    dur_q;
  logic                                    last_q;
  logic                                    load_en;
  logic                                    in_accept;

  mces_cfg_regs #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  assign lookup     = morse_lookup(char_code_i);
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  // Output register can take a segment when empty or being drained
  assign load_en    = !out_valid_q || !out_stall_i;

  // Sequence segments into the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      code_q      <= '0;
      main_q      <= 1'b0;
      sep_q       <= 1'b0;
      dur_q       <= '0;
      last_q      <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_accept) begin
            code_q  <= lookup.bits;
            cnt_q   <= lookup.len;
            state_q <= (lookup.len != '0) ? ST_ELEM_ON : ST_SEP_ON;
          end
        end
        ST_ELEM_ON: begin
          if (load_en) begin
            out_valid_q <= 1'b1;
            main_q      <= 1'b1;
            sep_q       <= 1'b0;
            last_q      <= 1'b0;
            dur_q       <= code_q[0] ? DUR_WIDTH'(cfg[CFG_DASH_ON])
                                     : DUR_WIDTH'(cfg[CFG_DOT_ON]);
            state_q     <= ST_ELEM_GAP;
          end
        end
        ST_ELEM_GAP: begin
          if (load_en) begin
            out_valid_q <= 1'b1;
            main_q      <= 1'b0;
            sep_q       <= 1'b0;
            last_q      <= 1'b0;
            dur_q       <= DUR_WIDTH'(cfg[CFG_ELEM_GAP]);
            // advance to the next element bit
            code_q      <= code_q >> 1;
            cnt_q       <= cnt_q - LEN_WIDTH'(1);
            state_q     <= (cnt_q == LEN_WIDTH'(1)) ? ST_SEP_ON : ST_ELEM_ON;
          end
        end
        ST_SEP_ON: begin
          if (load_en) begin
            out_valid_q <= 1'b1;
            main_q      <= 1'b0;
            sep_q       <= 1'b1;
            last_q      <= 1'b0;
            dur_q       <= DUR_WIDTH'(cfg[CFG_SEP_ON]);
            state_q     <= ST_SEP_OFF;
          end
        end
        ST_SEP_OFF: begin
          if (load_en) begin
            out_valid_q <= 1'b1;
            main_q      <= 1'b0;
            sep_q       <= 1'b0;
            last_q      <= 1'b1;
            dur_q       <= DUR_WIDTH'(cfg[CFG_SEP_OFF]);
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign main_lamp_o = main_q;
  assign sep_lamp_o  = sep_q;
  assign duration_o  = dur_q;
  assign last_o      = last_q;

  // Element states always have elements left to send
  a_elem_cnt_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ELEM_ON || state_q == ST_ELEM_GAP) |->
      (cnt_q != '0 && cnt_q <= LEN_WIDTH'(MAX_ELEMS)))
    else $error("element state with bad element count");

  // A gap is only pending behind a main-lamp on segment
  a_gap_after_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_ELEM_GAP |-> (out_valid_q && main_q))
    else $error("gap pending without main-lamp segment in output");

  // The off segment is only pending behind the separator pulse
  a_off_after_sep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SEP_OFF |-> (out_valid_q && sep_q && !last_q))
    else $error("separator off pending without separator pulse in output");

  // An accepted character starts a sequence
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q != ST_IDLE))
    else $error("accepted character did not start sequencing");

endmodule

// ----- rtl/mces_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// mces_cfg_regs: duration register file
// Five write-only duration registers, decoded by index; unknown indexes drop.
// ----------------------------------------------------------------------------
module mces_cfg_regs import mces_pkg::*; #(
  parameter int TIME_WIDTH = 16
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     cfg_we_i,
  input  logic [CFG_IDX_WIDTH-1:0]                 cfg_addr_i,
  input  logic [TIME_WIDTH-1:0]                    cfg_wdata_i,
  output logic [NUM_CFG_REGS-1:0][TIME_WIDTH-1:0]  cfg_o
);

  logic [NUM_CFG_REGS-1:0][TIME_WIDTH-1:0] cfg_q;

  // Load reset durations, then take writes at known indexes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q[CFG_DOT_ON]   <= TIME_WIDTH'(DOT_ON_RESET);
      cfg_q[CFG_DASH_ON]  <= TIME_WIDTH'(DASH_ON_RESET);
      cfg_q[CFG_ELEM_GAP] <= TIME_WIDTH'(ELEM_GAP_RESET);
      cfg_q[CFG_SEP_ON]   <= TIME_WIDTH'(SEP_ON_RESET);
      cfg_q[CFG_SEP_OFF]  <= TIME_WIDTH'(SEP_OFF_RESET);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_addr_i))
        CFG_DOT_ON:   cfg_q[CFG_DOT_ON]   <= cfg_wdata_i;
        CFG_DASH_ON:  cfg_q[CFG_DASH_ON]  <= cfg_wdata_i;
        CFG_ELEM_GAP: cfg_q[CFG_ELEM_GAP] <= cfg_wdata_i;
        CFG_SEP_ON:   cfg_q[CFG_SEP_ON]   <= cfg_wdata_i;
        CFG_SEP_OFF:  cfg_q[CFG_SEP_OFF]  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule
